>>> design/assert_macros.svh
// Assertion macros shared by the deque RTL.
// Standalone header; users supply clock, active-low reset and the checked terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: invariant");

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/deq_pkg.sv
// Shared types and codes of the double-ended queue.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package deq_pkg;

	localparam int DEQ_CAPACITY = 64;
	localparam int DATA_W       = 32;

	typedef logic [2:0]               func_t;
	typedef logic [1:0]               status_t;
	typedef logic signed [DATA_W-1:0] data_t;

	// operation codes
	localparam func_t FUNC_PUSH_FRONT = 3'd0;
	localparam func_t FUNC_PUSH_BACK  = 3'd1;
	localparam func_t FUNC_LIST       = 3'd2;
	localparam func_t FUNC_POP_FRONT  = 3'd3;
	localparam func_t FUNC_POP_BACK   = 3'd4;

	// result status codes
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

>>> design/deq_req_if.sv
// Request channel of the deque: valid/ready handshake carrying one operation.
// Depends on deq_pkg.
`default_nettype none

interface deq_req_if;
	import deq_pkg::*;

	logic  valid;
	logic  ready;
	func_t func;
	data_t value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

>>> design/deq_rsp_if.sv
// Response channel of the deque: valid/ready handshake carrying one result.
// Depends on deq_pkg.
`default_nettype none

interface deq_rsp_if;
	import deq_pkg::*;

	logic    valid;
	logic    ready;
	data_t   data_out;
	status_t status;
	logic    last_of_run;

	modport source (output valid, output data_out, output status, output last_of_run,
		input ready);
	modport sink   (input valid, input data_out, input status, input last_of_run,
		output ready);
endinterface

`default_nettype wire

>>> design/double_ended_queue.sv
// Double-ended queue top level: ring buffer in a one-port-read, one-port-write memory.
// Depends on deq_pkg, deq_req_if, deq_rsp_if and assert_macros.svh.
//
// Usage:
//   req carries one operation per beat (push front/back, list, pop front/back) and
//   a value used by pushes. rsp returns result beats: data_out, status and
//   last_of_run, which marks the final beat caused by a request.
//   A request is taken only while the block is idle; one request is worked on at
//   a time. A push or an error result is registered on rsp once the output
//   register is free, and the block then returns to idle for the next request.
//   A pop reads the memory once: its data passes through the read register into
//   the output register.
//   A list of N entries streams one memory read per cycle while the receiver keeps
//   up; it gives N beats, the last with last_of_run set.
//   Request codes 5 to 7 are dropped without a result.
//   A waiting result does not stop the next request beat from being taken; its
//   work waits for the output register. A stalled walk holds its read data.
//   Reset (arst_n low) empties the queue at once; no clearing pass is needed,
//   since only written entries are ever read.
`default_nettype none
`include "assert_macros.svh"

module double_ended_queue #(
	parameter int CAPACITY = deq_pkg::DEQ_CAPACITY
) (
	input  wire        clk,
	input  wire        arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);
	import deq_pkg::*;

	localparam int HW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_OP   = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;

	// ring position of head plus an offset below CAPACITY
	function automatic logic [HW-1:0] ring_add(input logic [HW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(CAPACITY)) begin
			sum = sum - SW'(CAPACITY);
		end
		return sum[HW-1:0];
	endfunction

	logic [1:0]    state_q;
	func_t         func_q;
	data_t         value_q;
	logic [HW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [HW-1:0] walk_pos_q;
	logic [CW-1:0] walk_rem_q;
	logic          rd_vld_s1;
	logic          last_s1;
	data_t         rdata_s1;
	logic          out_valid_q;
	data_t         out_data_q;
	status_t       out_status_q;
	logic          out_last_q;

	data_t         mem [CAPACITY];

	logic          slot_free;
	logic          is_push;
	logic          is_pop;
	logic          is_list;
	logic          full;
	logic          empty;
	logic [HW-1:0] head_prev;
	logic [HW-1:0] head_next;
	logic [HW-1:0] back_pos;
	logic          op_emit;
	status_t       op_status;
	logic          op_start;
	logic          wr_en;
	logic [HW-1:0] wr_addr;
	logic          walk_emit;
	logic          issue;
	logic [HW-1:0] walk_pos_next;

	// decode and ring arithmetic
	always_comb begin
		slot_free     = !out_valid_q || rsp.ready;
		is_push       = (func_q == FUNC_PUSH_FRONT) || (func_q == FUNC_PUSH_BACK);
		is_pop        = (func_q == FUNC_POP_FRONT) || (func_q == FUNC_POP_BACK);
		is_list       = (func_q == FUNC_LIST);
		full          = (count_q == CW'(CAPACITY));
		empty         = (count_q == '0);
		head_prev     = (head_q == '0) ? HW'(CAPACITY - 1) : head_q - HW'(1);
		head_next     = (head_q == HW'(CAPACITY - 1)) ? '0 : head_q + HW'(1);
		back_pos      = ring_add(head_q, count_q - CW'(1));
		walk_pos_next = (walk_pos_q == HW'(CAPACITY - 1)) ? '0 : walk_pos_q + HW'(1);
	end

	// single-result operations and walk setup
	always_comb begin
		op_emit   = (state_q == ST_OP) && slot_free &&
			(is_push || ((is_pop || is_list) && empty));
		op_status = is_push ? (full ? STATUS_FULL : STATUS_OK) : STATUS_EMPTY;
		op_start  = (state_q == ST_OP) && (is_pop || is_list) && !empty;
		wr_en     = (state_q == ST_OP) && is_push && !full && slot_free;
		wr_addr   = (func_q == FUNC_PUSH_FRONT) ? head_prev : ring_add(head_q, count_q);
	end

	// read pipe: one memory read per cycle while the output keeps up
	always_comb begin
		walk_emit = rd_vld_s1 && slot_free;
		issue     = (state_q == ST_WALK) && (walk_rem_q != '0) && (!rd_vld_s1 || walk_emit);
	end

	assign req.ready = (state_q == ST_IDLE);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			walk_rem_q  <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_OP;
					end
				end
				ST_OP: begin
					if (op_emit) begin
						state_q <= ST_IDLE;
					end else if (op_start) begin
						state_q <= ST_WALK;
					end else if (!is_push && !is_pop && !is_list) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (walk_emit && last_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (wr_en) begin
				count_q <= count_q + CW'(1);
				if (func_q == FUNC_PUSH_FRONT) begin
					head_q <= head_prev;
				end
			end

			if (op_start) begin
				walk_rem_q <= is_list ? count_q : CW'(1);
				if (is_pop) begin
					count_q <= count_q - CW'(1);
				end
				if (func_q == FUNC_POP_FRONT) begin
					head_q <= head_next;
				end
			end else if (issue) begin
				walk_rem_q <= walk_rem_q - CW'(1);
			end

			if (issue) begin
				rd_vld_s1 <= 1'b1;
			end else if (walk_emit) begin
				rd_vld_s1 <= 1'b0;
			end

			if (op_emit || walk_emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q  <= req.func;
			value_q <= req.value;
		end
		if (op_start) begin
			walk_pos_q <= (func_q == FUNC_POP_BACK) ? back_pos : head_q;
		end else if (issue) begin
			walk_pos_q <= walk_pos_next;
		end
		if (issue) begin
			last_s1 <= (walk_rem_q == CW'(1));
		end
		if (walk_emit) begin
			out_data_q   <= rdata_s1;
			out_status_q <= STATUS_OK;
			out_last_q   <= last_s1;
		end else if (op_emit) begin
			out_data_q   <= '0;
			out_status_q <= op_status;
			out_last_q   <= 1'b1;
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value_q;
		end
		if (issue) begin
			rdata_s1 <= mem[walk_pos_q];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.data_out    = out_data_q;
	assign rsp.status      = out_status_q;
	assign rsp.last_of_run = out_last_q;

	// checks
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(CAPACITY))
	`ASSERT_ALWAYS(a_head_bound, clk, arst_n, head_q <= HW'(CAPACITY - 1))
	`ASSERT_ALWAYS(a_no_rw_overlap, clk, arst_n, !(wr_en && issue))
	`ASSERT_IMPL(a_rd_in_walk, clk, arst_n, rd_vld_s1, state_q == ST_WALK)
	`ASSERT_NEXT(a_accept_to_op, clk, arst_n, req.valid && req.ready, state_q == ST_OP)

endmodule

`default_nettype wire

>>> sim/deq_checker.sv
// Scoreboard for the double-ended queue: watches both channels, predicts every result beat.
// Depends on deq_pkg, deq_req_if and deq_rsp_if.
`default_nettype none

module deq_checker #(
	parameter int CAPACITY = deq_pkg::DEQ_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	deq_req_if   req,
	deq_rsp_if   rsp,
	output int   errors,
	output int   pending,
	output int   checked
);
	import deq_pkg::*;

	localparam int HEAD_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SHOW_MAX = 30;

	typedef struct packed {
		data_t   data;
		status_t status;
		logic    last;
	} deq_beat_t;

	// shadow copy of the ring and the beats it still owes
	data_t             ring [CAPACITY];
	logic [HEAD_W-1:0] head;
	logic [CNT_W-1:0]  count;
	deq_beat_t         beats_owed [$];

	function automatic int unsigned ring_slot(int unsigned offset);
		return (head + offset) % CAPACITY;
	endfunction

	task automatic owe(data_t data, status_t status, logic last);
		deq_beat_t b;
		b.data   = data;
		b.status = status;
		b.last   = last;
		beats_owed.push_back(b);
	endtask

	// apply one request to the shadow ring and queue the beats it must produce
	task automatic apply_request(func_t func, data_t value);
		data_t popped;
		case (func)
			FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
				if (count == CAPACITY) begin
					owe('0, STATUS_FULL, 1'b1);
				end else begin
					if (func == FUNC_PUSH_FRONT) begin
						head = HEAD_W'(ring_slot(CAPACITY - 1));
						ring[head] = value;
					end else begin
						ring[ring_slot(count)] = value;
					end
					count = count + 1'b1;
					owe('0, STATUS_OK, 1'b1);
				end
			end
			FUNC_LIST: begin
				if (count == 0) begin
					owe('0, STATUS_EMPTY, 1'b1);
				end else begin
					for (int unsigned i = 0; i < count; i++)
						owe(ring[ring_slot(i)], STATUS_OK, (i + 1 == count));
				end
			end
			FUNC_POP_FRONT, FUNC_POP_BACK: begin
				if (count == 0) begin
					owe('0, STATUS_EMPTY, 1'b1);
				end else begin
					if (func == FUNC_POP_FRONT) begin
						popped = ring[head];
						head = HEAD_W'(ring_slot(1));
					end else begin
						popped = ring[ring_slot(count - 1)];
					end
					count = count - 1'b1;
					owe(popped, STATUS_OK, 1'b1);
				end
			end
			default: ;  // unused codes are dropped by the block
		endcase
	endtask

	task automatic flag(string field, longint want, longint got);
		if (errors < SHOW_MAX)
			$display("%0t: %s expected %0d got %0d", $time, field, want, got);
		errors++;
	endtask

	// result beats are checked before the request of the same edge is applied;
	// no request can produce a beat in the cycle it is taken
	always @(posedge clk or negedge arst_n) begin : watch
		deq_beat_t due;
		if (!arst_n) begin
			head    = '0;
			count   = '0;
			beats_owed.delete();
			errors  = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				checked++;
				if (beats_owed.size() == 0) begin
					if (errors < SHOW_MAX)
						$display("%0t: unexpected beat data_out %0d status %0d last %0b",
							$time, rsp.data_out, rsp.status, rsp.last_of_run);
					errors++;
				end else begin
					due = beats_owed.pop_front();
					if (rsp.data_out !== due.data)
						flag("data_out", due.data, rsp.data_out);
					if (rsp.status !== due.status)
						flag("status", due.status, rsp.status);
					if (rsp.last_of_run !== due.last)
						flag("last_of_run", due.last, rsp.last_of_run);
				end
			end
			if (req.valid && req.ready)
				apply_request(req.func, req.value);
			pending = beats_owed.size();
		end
	end

endmodule

`default_nettype wire

>>> sim/tb_double_ended_queue.sv
// Testbench top for the double-ended queue: clock, reset, request stimulus, receiver stalls.
// Depends on deq_pkg, the two channel interfaces, double_ended_queue and deq_checker.
`default_nettype none

module tb_double_ended_queue;
	import deq_pkg::*;

	localparam int    CAPACITY       = DEQ_CAPACITY;
	localparam int    RANDOM_ITEMS   = 400;
	localparam int    WATCHDOG_LIMIT = 2000;
	localparam int    SETTLE_CYCLES  = 16;
	localparam func_t FUNC_UNUSED_LO = 3'd5;
	localparam func_t FUNC_UNUSED_HI = 3'd7;

	typedef enum int { FILL_UP, DRAIN, MIXED } traffic_t;

	logic clk;
	logic arst_n;
	int   chk_errors;
	int   beats_due;
	int   beats_checked;

	// running occupancy, used only to count refused pushes and empty pops
	int fill_lvl;
	int n_push, n_pop, n_list, n_unused, n_full_hits, n_empty_hits;

	deq_req_if req ();
	deq_rsp_if rsp ();

	double_ended_queue #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	deq_checker #(.CAPACITY(CAPACITY)) chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.errors  (chk_errors),
		.pending (beats_due),
		.checked (beats_checked)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: stretches of always-ready, periodic, random and heavy stalling
	initial begin : rsp_stall
		int mode;
		int left;
		int phase;
		rsp.ready = 1'b0;
		left  = 0;
		phase = 0;
		mode  = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(30, 150);
			end
			left--;
			phase++;
			case (mode)
				0:       rsp.ready <= 1'b1;
				1:       rsp.ready <= (phase % 4) != 3;
				2:       rsp.ready <= 1'($urandom_range(0, 1));
				default: rsp.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// one request beat; valid is left high for a following beat
	task automatic send_req(func_t func, data_t value);
		@(negedge clk);
		req.valid <= 1'b1;
		req.func  <= func;
		req.value <= value;
		do @(posedge clk); while (!req.ready);
		case (func)
			FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
				n_push++;
				if (fill_lvl < CAPACITY) fill_lvl++;
				else n_full_hits++;
			end
			FUNC_POP_FRONT, FUNC_POP_BACK: begin
				n_pop++;
				if (fill_lvl > 0) fill_lvl--;
				else n_empty_hits++;
			end
			FUNC_LIST: n_list++;
			default:   n_unused++;
		endcase
	endtask

	task automatic idle_req(int cycles);
		@(negedge clk);
		req.valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	function automatic data_t pick_value();
		case ($urandom_range(0, 5))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return data_t'(int'($urandom_range(0, 15)) - 8);
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic func_t pick_func(traffic_t traffic);
		int    r;
		func_t push_op;
		func_t pop_op;
		r       = $urandom_range(0, 99);
		push_op = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
		pop_op  = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
		if (r < 3)
			return func_t'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
		case (traffic)
			FILL_UP: return (r < 8) ? FUNC_LIST : (r < 18) ? pop_op : push_op;
			DRAIN:   return (r < 8) ? FUNC_LIST : (r < 18) ? push_op : pop_op;
			default: return (r < 10) ? FUNC_LIST : (r < 55) ? push_op : pop_op;
		endcase
	endfunction

	// a quiet counter, cleared by reset or by any beat on either channel, ends the run at WATCHDOG_LIMIT
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int       done_items;
		int       seg_left;
		int       burst_left;
		int       seg_no;
		traffic_t traffic;
		func_t    func;

		req.valid = 1'b0;
		req.func  = FUNC_PUSH_FRONT;
		req.value = '0;
		fill_lvl  = 0;
		n_push = 0; n_pop = 0; n_list = 0; n_unused = 0;
		n_full_hits = 0; n_empty_hits = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty store, unused codes, extremes, wrap of the front pointer
		send_req(FUNC_POP_FRONT, 32'sd5);
		send_req(FUNC_POP_BACK, -32'sd5);
		send_req(FUNC_LIST, '0);
		send_req(FUNC_UNUSED_LO, 32'sd1);
		send_req(func_t'(FUNC_UNUSED_LO + 1), 32'sd2);
		send_req(FUNC_UNUSED_HI, 32'sh7FFF_FFFF);
		idle_req(3);
		send_req(FUNC_PUSH_FRONT, 32'sh7FFF_FFFF);
		send_req(FUNC_PUSH_BACK, 32'sh8000_0000);
		send_req(FUNC_PUSH_FRONT, '0);
		send_req(FUNC_PUSH_BACK, -32'sd1);
		send_req(FUNC_PUSH_BACK, 32'sh5A5A_A5A5);
		send_req(FUNC_LIST, 32'sh1234_5678);
		idle_req(2);
		send_req(FUNC_POP_FRONT, '0);
		send_req(FUNC_POP_BACK, '0);
		send_req(FUNC_LIST, '0);
		send_req(FUNC_POP_FRONT, '0);
		send_req(FUNC_POP_BACK, '0);
		send_req(FUNC_POP_FRONT, '0);
		send_req(FUNC_POP_BACK, '0);
		send_req(FUNC_LIST, '0);

		// random: a push-heavy fill segment and a pop-heavy drain segment, then mixed segments
		done_items = 0;
		seg_left   = 0;
		seg_no     = 0;
		burst_left = $urandom_range(1, 12);
		traffic    = FILL_UP;
		while (done_items < RANDOM_ITEMS) begin
			if (seg_left == 0) begin
				case (seg_no)
					0:       traffic = FILL_UP;
					1:       traffic = DRAIN;
					default: traffic = traffic_t'($urandom_range(0, 2));
				endcase
				seg_left = (seg_no < 2) ? 100 : $urandom_range(20, 90);
				seg_no++;
			end
			if (burst_left == 0) begin
				idle_req($urandom_range(1, 10));
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
					: $urandom_range(1, 12);
			end
			func = pick_func(traffic);
			send_req(func, pick_value());
			burst_left--;
			if (func <= FUNC_POP_BACK) begin
				done_items++;
				seg_left--;
			end
		end
		idle_req(1);

		// drain outstanding beats, then let any dropped request clear the pipe
		while (beats_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d pushes (%0d refused as full), %0d pops (%0d on empty),",
			n_push, n_full_hits, n_pop, n_empty_hits);
		$display("%0d lists, %0d unused codes; %0d result beats compared, %0d still owed",
			n_list, n_unused, beats_checked, beats_due);
		if (chk_errors == 0 && beats_due == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
